@@ rtl/piox_pkg.sv @@
// Package for the PIO instruction executor: payload structs, opcodes and codes.
// No dependencies.
package piox_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] instruction;
        logic [31:0] pin_inputs;
        logic [31:0] status_value;
        logic [31:0] host_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pin_levels;
        logic [31:0] pin_directions;
        logic        stalled;
        logic        jump;
        logic [4:0]  jump_target;
        logic        exec_request;
        logic [15:0] exec_word;
        logic [31:0] rx_data;
        logic        rx_valid;
        logic [2:0]  tx_level;
        logic [2:0]  rx_level;
        logic        host_rejected;
    } t_out_item;

    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_PUSH = 2'd1;
    localparam logic [1:0] MODE_POP  = 2'd2;

    localparam logic [2:0] OP_JMP  = 3'd0;
    localparam logic [2:0] OP_WAIT = 3'd1;
    localparam logic [2:0] OP_IN   = 3'd2;
    localparam logic [2:0] OP_OUT  = 3'd3;
    localparam logic [2:0] OP_PP   = 3'd4;
    localparam logic [2:0] OP_MOV  = 3'd5;
    localparam logic [2:0] OP_IRQ  = 3'd6;
    localparam logic [2:0] OP_SET  = 3'd7;

    localparam logic [2:0] REG_IN_BASE   = 3'd0;
    localparam logic [2:0] REG_OUT_BASE  = 3'd1;
    localparam logic [2:0] REG_OUT_COUNT = 3'd2;
    localparam logic [2:0] REG_SET_BASE  = 3'd3;
    localparam logic [2:0] REG_SET_COUNT = 3'd4;
    localparam logic [2:0] REG_JUMP_PIN  = 3'd5;
    localparam logic [2:0] REG_SHIFT     = 3'd6;
    localparam logic [2:0] REG_THRESH    = 3'd7;

    localparam logic [2:0] WF_PUSH = 3'b001;
    localparam logic [2:0] WF_PULL = 3'b010;
    localparam logic [2:0] WF_IRQ  = 3'b100;

    function automatic logic [31:0] f_lowmask(input logic [5:0] n);
        f_lowmask = n[5] ? 32'hffff_ffff : ((32'd1 << n[4:0]) - 32'd1);
    endfunction

    function automatic logic [5:0] f_thr(input logic [5:0] v);
        f_thr = (v == 6'd0 || v > 6'd32) ? 6'd32 : v;
    endfunction

    function automatic logic [31:0] f_rot(input logic [31:0] p, input logic [4:0] b);
        f_rot = (p >> b) | (p << (6'd32 - {1'b0, b}));
    endfunction

    function automatic logic [31:0] f_put(input logic [31:0] dst, input logic [4:0] base,
                                          input logic [5:0] n, input logic [31:0] data);
        logic [31:0] m;
        m = f_lowmask(n);
        f_put = (dst & ~f_rot(m, 5'd0 - base)) | (f_rot(data & m, 5'd0 - base));
    endfunction

endpackage

@@ rtl/pio_instruction_executor.sv @@
// Top level of the PIO instruction executor: state, instruction decode, result register.
// Depends on piox_pkg and piox_fifo.
//
// Channel   Direction  Handshake         Payload
// in        input      valid / stall     piox_pkg::t_in_item
// out       output     valid / stall     piox_pkg::t_out_item
// cfg       input      valid / ready     index (3), data (12)
//
// All executor state updates happen at the accepting edge, which also loads the output
// register. Reset is synchronous: it clears configuration, executor state and both FIFO
// fill counts, but sets the OSR count to 32 and leaves the output payload as it was.
// A stalled output holds its result; input is taken whenever the output register is empty or being emptied.
module pio_instruction_executor #(
    parameter int FIFO_DEPTH = 4,
    parameter int SM_ID      = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  piox_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output piox_pkg::t_out_item  o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [11:0]          i_cfg_data
);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(FIFO_DEPTH);

    logic [4:0]  r_in_base, r_out_base, r_set_base, r_jump_pin;
    logic [5:0]  r_out_count;
    logic [2:0]  r_set_count;
    logic [3:0]  r_shift;
    logic [11:0] r_thr;

    logic [31:0] r_x, r_y, r_isr, r_osr, r_pout, r_pdir;
    logic [31:0] n_x, n_y, n_isr, n_osr, n_pout, n_pdir;
    logic [5:0]  r_icnt, r_ocnt, n_icnt, n_ocnt;
    logic [7:0]  r_irq, n_irq;
    logic [2:0]  r_wf, n_wf;
    logic        r_valid;
    piox_pkg::t_out_item r_out, n_out;

    logic          tx_push, tx_pop, rx_push, rx_pop;
    logic [31:0]   tx_head, rx_head, rx_wdata;
    logic [CW-1:0] tx_fill, rx_fill;

    logic accept;
    assign o_stall     = r_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_data      = r_out;

    piox_fifo #(.DEPTH(FIFO_DEPTH)) u_tx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(tx_push), .i_data(i_data.host_data),
        .i_pop(tx_pop), .o_head(tx_head), .o_fill(tx_fill)
    );
    piox_fifo #(.DEPTH(FIFO_DEPTH)) u_rx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(rx_push), .i_data(rx_wdata),
        .i_pop(rx_pop), .o_head(rx_head), .o_fill(rx_fill)
    );

    function automatic logic [2:0] f_irq_idx(input logic [4:0] idx);
        logic [1:0] s;
        s = idx[1:0] + 2'(SM_ID);
        f_irq_idx = idx[4] ? {idx[2], s} : idx[2:0];
    endfunction

    always_comb begin
        logic [2:0]  op, f75, q;
        logic [4:0]  low5;
        logic [5:0]  n, pushthr, pullthr, cnt;
        logic [31:0] data, mask, src_v;
        logic [31:0] isr_sh;
        logic [6:0]  csum;
        logic        take, pulled, pol;
        logic [15:0] ins;
        ins     = i_data.instruction;
        op      = ins[15:13];
        f75     = ins[7:5];
        low5    = ins[4:0];
        n       = (low5 == 5'd0) ? 6'd32 : {1'b0, low5};
        pushthr = piox_pkg::f_thr(r_thr[5:0]);
        pullthr = piox_pkg::f_thr(r_thr[11:6]);
        mask    = piox_pkg::f_lowmask(n);
        q       = f_irq_idx(low5);
        pol     = ins[7];
        take    = 1'b0;
        pulled  = 1'b0;
        data    = '0;
        src_v   = '0;
        isr_sh  = '0;
        csum    = '0;
        cnt     = '0;
        n_x = r_x; n_y = r_y; n_isr = r_isr; n_osr = r_osr;
        n_icnt = r_icnt; n_ocnt = r_ocnt; n_irq = r_irq; n_wf = r_wf;
        n_pout = r_pout; n_pdir = r_pdir;
        tx_push = 1'b0; tx_pop = 1'b0; rx_push = 1'b0; rx_pop = 1'b0;
        rx_wdata = r_isr;
        n_out = '0;

        unique case (i_data.mode)
            piox_pkg::MODE_PUSH: begin
                if (tx_fill < FULL) tx_push = 1'b1;
                else n_out.host_rejected = 1'b1;
            end
            piox_pkg::MODE_POP: begin
                if (rx_fill != '0) begin
                    rx_pop = 1'b1;
                    n_out.rx_valid = 1'b1;
                    n_out.rx_data = rx_head;
                end else begin
                    n_out.host_rejected = 1'b1;
                end
            end
            piox_pkg::MODE_EXEC: begin
                if (op != piox_pkg::OP_IN)  n_wf = n_wf & ~piox_pkg::WF_PUSH;
                if (op != piox_pkg::OP_IRQ) n_wf = n_wf & ~piox_pkg::WF_IRQ;
                unique case (op)
                    piox_pkg::OP_JMP: begin
                        unique case (f75)
                            3'd0: take = 1'b1;
                            3'd1: take = r_x == '0;
                            3'd2: begin take = r_x != '0; n_x = r_x - 32'd1; end
                            3'd3: take = r_y == '0;
                            3'd4: begin take = r_y != '0; n_y = r_y - 32'd1; end
                            3'd5: take = r_x != r_y;
                            3'd6: take = i_data.pin_inputs[r_jump_pin];
                            default: take = r_ocnt < pullthr;
                        endcase
                        if (take) begin
                            n_out.jump = 1'b1;
                            n_out.jump_target = low5;
                        end
                    end
                    piox_pkg::OP_WAIT: begin
                        unique case (ins[6:5])
                            2'd0: n_out.stalled = i_data.pin_inputs[low5] != pol;
                            2'd1: n_out.stalled =
                                i_data.pin_inputs[r_in_base + low5] != pol;
                            2'd2: begin
                                if (r_irq[q] != pol) n_out.stalled = 1'b1;
                                else if (pol) n_irq[q] = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    piox_pkg::OP_IN: begin
                        if (r_wf[0]) begin
                            if (rx_fill < FULL) begin
                                rx_push = 1'b1; n_isr = '0; n_icnt = '0;
                                n_wf = n_wf & ~piox_pkg::WF_PUSH;
                            end else begin
                                n_out.stalled = 1'b1;
                            end
                        end else if (f75 != 3'd4 && f75 != 3'd5) begin
                            unique case (f75)
                                3'd0: src_v = piox_pkg::f_rot(i_data.pin_inputs, r_in_base);
                                3'd1: src_v = r_x;
                                3'd2: src_v = r_y;
                                3'd6: src_v = r_isr;
                                3'd7: src_v = r_osr;
                                default: src_v = '0;
                            endcase
                            data = src_v & mask;
                            if (r_shift[0]) begin
                                isr_sh = n[5] ? data : ((r_isr >> n[4:0]) |
                                         (data << (6'd32 - n)));
                            end else begin
                                isr_sh = n[5] ? data : ((r_isr << n[4:0]) | data);
                            end
                            csum = {1'b0, r_icnt} + {1'b0, n};
                            cnt = (csum > 7'd32) ? 6'd32 : csum[5:0];
                            n_isr = isr_sh; n_icnt = cnt;
                            rx_wdata = isr_sh;
                            if (r_shift[2] && cnt >= pushthr) begin
                                if (rx_fill < FULL) begin
                                    rx_push = 1'b1; n_isr = '0; n_icnt = '0;
                                end else begin
                                    n_out.stalled = 1'b1;
                                    n_wf = n_wf | piox_pkg::WF_PUSH;
                                end
                            end
                        end
                    end
                    piox_pkg::OP_OUT: begin
                        if (r_shift[3] && r_ocnt >= pullthr) begin
                            if (tx_fill != '0) begin
                                pulled = 1'b1;
                            end
                            n_out.stalled = 1'b1;
                            n_wf = n_wf | piox_pkg::WF_PULL;
                        end else begin
                            if (r_shift[1]) begin
                                data = r_osr & mask;
                                n_osr = n[5] ? '0 : (r_osr >> n[4:0]);
                            end else begin
                                data = n[5] ? r_osr : ((r_osr >> (6'd32 - n)) & mask);
                                n_osr = n[5] ? '0 : (r_osr << n[4:0]);
                            end
                            csum = {1'b0, r_ocnt} + {1'b0, n};
                            n_ocnt = (csum > 7'd32) ? 6'd32 : csum[5:0];
                            unique case (f75)
                                3'd0: n_pout = piox_pkg::f_put(r_pout, r_out_base, n, data);
                                3'd1: n_x = data;
                                3'd2: n_y = data;
                                3'd3: ;
                                3'd4: n_pdir = piox_pkg::f_put(r_pdir, r_out_base, n, data);
                                3'd5: begin
                                    n_out.jump = 1'b1;
                                    n_out.jump_target = data[4:0];
                                end
                                3'd6: begin n_isr = data; n_icnt = n; end
                                default: begin
                                    n_out.exec_request = 1'b1;
                                    n_out.exec_word = data[15:0];
                                end
                            endcase
                        end
                    end
                    piox_pkg::OP_PP: begin
                        if (!ins[7]) begin
                            if (rx_fill < FULL) begin
                                if (!ins[6] || r_icnt >= pushthr) begin
                                    rx_push = 1'b1; n_isr = '0; n_icnt = '0;
                                end
                            end else if (ins[5]) begin
                                n_out.stalled = 1'b1;
                            end else begin
                                n_isr = '0; n_icnt = '0;
                            end
                        end else begin
                            if (tx_fill != '0) begin
                                if (!ins[6] || r_ocnt >= pullthr) pulled = 1'b1;
                            end else if (ins[5]) begin
                                n_out.stalled = 1'b1;
                                n_wf = n_wf | piox_pkg::WF_PULL;
                            end else begin
                                n_osr = r_x; n_ocnt = '0;
                                n_wf = n_wf & ~piox_pkg::WF_PULL;
                            end
                        end
                    end
                    piox_pkg::OP_MOV: begin
                        if (ins[2:0] != 3'd4) begin
                            unique case (ins[2:0])
                                3'd0: data = piox_pkg::f_rot(i_data.pin_inputs, r_in_base);
                                3'd1: data = r_x;
                                3'd2: data = r_y;
                                3'd5: data = i_data.status_value;
                                3'd6: data = r_isr;
                                3'd7: data = r_osr;
                                default: data = '0;
                            endcase
                            if (ins[4:3] == 2'd1) data = ~data;
                            else if (ins[4:3] == 2'd2) data = {<<{data}};
                            unique case (f75)
                                3'd0: n_pout = piox_pkg::f_put(r_pout, r_out_base,
                                    (r_out_count > 6'd32) ? 6'd32 : r_out_count, data);
                                3'd1: n_x = data;
                                3'd2: n_y = data;
                                3'd3: ;
                                3'd4: begin
                                    n_out.exec_request = 1'b1;
                                    n_out.exec_word = data[15:0];
                                end
                                3'd5: begin
                                    n_out.jump = 1'b1;
                                    n_out.jump_target = data[4:0];
                                end
                                3'd6: begin n_isr = data; n_icnt = '0; end
                                default: begin n_osr = data; n_ocnt = '0; end
                            endcase
                        end
                    end
                    piox_pkg::OP_IRQ: begin
                        if (r_wf[2]) begin
                            if (r_irq[q]) n_out.stalled = 1'b1;
                            else n_wf = n_wf & ~piox_pkg::WF_IRQ;
                        end else if (ins[6]) begin
                            n_irq[q] = 1'b0;
                        end else begin
                            n_irq[q] = 1'b1;
                            if (ins[5]) begin
                                n_wf = n_wf | piox_pkg::WF_IRQ;
                                n_out.stalled = 1'b1;
                            end
                        end
                    end
                    default: begin
                        cnt = (r_set_count > 3'd5) ? 6'd5 : {3'b0, r_set_count};
                        unique case (f75)
                            3'd0: n_pout = piox_pkg::f_put(r_pout, r_set_base, cnt,
                                                           {27'b0, low5});
                            3'd1: n_x = {27'b0, low5};
                            3'd2: n_y = {27'b0, low5};
                            3'd4: n_pdir = piox_pkg::f_put(r_pdir, r_set_base, cnt,
                                                           {27'b0, low5});
                            default: ;
                        endcase
                    end
                endcase
                if (r_shift[3] && op != piox_pkg::OP_OUT && op != piox_pkg::OP_MOV &&
                    !(op == piox_pkg::OP_PP && ins[7]) && n_ocnt >= pullthr &&
                    tx_fill != '0) begin
                    pulled = 1'b1;
                end
                if (pulled) begin
                    tx_pop = 1'b1; n_osr = tx_head; n_ocnt = '0;
                    n_wf = n_wf & ~piox_pkg::WF_PULL;
                end
            end
            default: ;
        endcase

        if (!accept) begin
            tx_push = 1'b0; tx_pop = 1'b0; rx_push = 1'b0; rx_pop = 1'b0;
        end
        n_out.pin_levels     = n_pout;
        n_out.pin_directions = n_pdir;
        n_out.tx_level = 3'(tx_fill + CW'(tx_push) - CW'(tx_pop));
        n_out.rx_level = 3'(rx_fill + CW'(rx_push) - CW'(rx_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base <= '0; r_out_base <= '0; r_out_count <= '0; r_set_base <= '0;
            r_set_count <= '0; r_jump_pin <= '0; r_shift <= '0; r_thr <= '0;
            r_x <= '0; r_y <= '0; r_isr <= '0; r_osr <= '0;
            r_icnt <= '0; r_ocnt <= 6'd32; r_irq <= '0; r_wf <= '0;
            r_pout <= '0; r_pdir <= '0; r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    piox_pkg::REG_IN_BASE:   r_in_base   <= i_cfg_data[4:0];
                    piox_pkg::REG_OUT_BASE:  r_out_base  <= i_cfg_data[4:0];
                    piox_pkg::REG_OUT_COUNT: r_out_count <= i_cfg_data[5:0];
                    piox_pkg::REG_SET_BASE:  r_set_base  <= i_cfg_data[4:0];
                    piox_pkg::REG_SET_COUNT: r_set_count <= i_cfg_data[2:0];
                    piox_pkg::REG_JUMP_PIN:  r_jump_pin  <= i_cfg_data[4:0];
                    piox_pkg::REG_SHIFT:     r_shift     <= i_cfg_data[3:0];
                    default:                 r_thr       <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_x <= n_x; r_y <= n_y; r_isr <= n_isr; r_osr <= n_osr;
                r_icnt <= n_icnt; r_ocnt <= n_ocnt; r_irq <= n_irq; r_wf <= n_wf;
                r_pout <= n_pout; r_pdir <= n_pdir;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    a_level_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_out.tx_level == 3'(tx_fill) && r_out.rx_level == 3'(rx_fill)))
        else $error("level mismatch");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tx_fill <= FULL && rx_fill <= FULL) else $error("fifo overflow");
    a_rx_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !(r_out.rx_valid && r_out.host_rejected)) else $error("rx flags");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid) else $error("output lost");
endmodule

@@ rtl/piox_fifo.sv @@
// Small word FIFO in flip-flops with same-cycle push/pop result handling.
// Depends on nothing but its parameters.
module piox_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [31:0]                i_data,
    input  logic                       i_pop,
    output logic [31:0]                o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_fill
);
    localparam int CW = $clog2(DEPTH + 1);
    logic [31:0]   r_mem [DEPTH];
    logic [CW-1:0] r_fill;

    assign o_head = r_mem[0];
    assign o_fill = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= r_fill + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_pop) begin
                if (k + 1 < DEPTH) begin
                    r_mem[k] <= r_mem[k + 1];
                end
                if (i_push && CW'(k + 1) == r_fill) begin
                    r_mem[k] <= i_data;
                end
            end else if (i_push && CW'(k) == r_fill) begin
                r_mem[k] <= i_data;
            end
        end
    end
endmodule
